### hw/rtl/ssko_pkg.sv
package ssko_pkg;

  // Stream field widths
  localparam int FIELD_W    = 32;
  localparam int IN_DATA_W  = 3 * FIELD_W;
  localparam int PCT_W      = 15;
  localparam int OUT_DATA_W = ((PCT_W + 7) / 8) * 8;

  // Configuration registers
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam int KP_CFG_W   = 6;
  localparam int SL_CFG_W   = 4;
  localparam logic [KP_CFG_W-1:0] KP_RESET = 6'd5;
  localparam logic [SL_CFG_W-1:0] SL_RESET = 4'd3;
  // register select is paddr[2]
  localparam logic REG_K_PERIOD = 1'b0;
  localparam logic REG_SLOWING  = 1'b1;

  // Bar counter
  localparam int SEEN_W = 6;
  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

  // 100 percent with 8 fraction bits
  localparam logic [PCT_W-1:0] FULL_SCALE = 15'd25600;

  // Parameter defaults
  localparam int DEF_MAX_K_PERIOD = 32;
  localparam int DEF_MAX_SLOWING  = 8;
  localparam int DEF_PRICE_WIDTH  = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_MUL,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

endpackage

### hw/rtl/ssko_ram.sv
module ssko_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/ssko_lanes.sv
// One lane per slowing bar: running highest high / lowest low over its window,
// fed by one history entry per cycle (newest first). A lane closes when the
// sweep passes the end of its window; its terms go into the sums next cycle.
module ssko_lanes #(
  parameter int PW     = 32,
  parameter int MAX_SL = 8,
  parameter int AW     = 6,
  parameter int KW     = 6,
  parameter int SLW    = 4,
  parameter int SW     = PW + 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 clear_i,
  input  logic                 rd_vld_i,
  input  logic [AW-1:0]        rd_age_i,
  input  logic [PW-1:0]        rd_high_i,
  input  logic [PW-1:0]        rd_low_i,
  input  logic [PW-1:0]        rd_close_i,
  input  logic [KW-1:0]        kp_i,
  input  logic [SLW-1:0]       sl_i,
  output logic signed [SW-1:0] num_o,
  output logic signed [SW-1:0] den_o,
  output logic                 done_o
);

  localparam int LW = (MAX_SL > 1) ? $clog2(MAX_SL) : 1;

  logic [PW-1:0] hh_q [MAX_SL];
  logic [PW-1:0] ll_q [MAX_SL];
  logic [PW-1:0] cl_q [MAX_SL];

  logic                 fin_hit;
  logic [LW-1:0]        fin_idx_d;
  logic [LW-1:0]        fin_idx_q;
  logic                 fin_vld_q;
  logic                 done_q;
  logic signed [SW-1:0] num_q;
  logic signed [SW-1:0] den_q;
  logic signed [SW-1:0] num_term;
  logic signed [SW-1:0] den_term;

  always_ff @(posedge clk_i) begin
    if (rd_vld_i) begin
      for (int j = 0; j < MAX_SL; j++) begin
        if (int'(rd_age_i) == j) begin
          hh_q[j] <= rd_high_i;
          ll_q[j] <= rd_low_i;
          cl_q[j] <= rd_close_i;
        end else if (int'(rd_age_i) > j && int'(rd_age_i) < j + int'(kp_i)) begin
          if (rd_high_i > hh_q[j]) hh_q[j] <= rd_high_i;
          if (rd_low_i < ll_q[j]) ll_q[j] <= rd_low_i;
        end
      end
    end
  end

  // lane (age - kp + 1) sees its oldest bar in this cycle
  always_comb begin
    int fin_pos;
    fin_pos   = int'(rd_age_i) - int'(kp_i) + 1;
    fin_hit   = rd_vld_i && (fin_pos >= 0) && (fin_pos < int'(sl_i));
    fin_idx_d = LW'(fin_pos);
  end

  assign num_term = $signed(SW'(cl_q[fin_idx_q])) - $signed(SW'(ll_q[fin_idx_q]));
  assign den_term = $signed(SW'(hh_q[fin_idx_q])) - $signed(SW'(ll_q[fin_idx_q]));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_vld_q <= 1'b0;
      fin_idx_q <= '0;
      done_q    <= 1'b0;
    end else begin
      fin_vld_q <= fin_hit & ~clear_i;
      fin_idx_q <= fin_idx_d;
      done_q    <= fin_vld_q && (int'(fin_idx_q) == int'(sl_i) - 1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      num_q <= '0;
      den_q <= '0;
    end else if (fin_vld_q) begin
      num_q <= num_q + num_term;
      den_q <= den_q + den_term;
    end
  end

  assign num_o  = num_q;
  assign den_o  = den_q;
  assign done_o = done_q;

endmodule

### hw/rtl/ssko_div.sv
// floor(num * FULL_SCALE / den) for 0 < num < den, else pinned to 0 or FULL_SCALE: one
// constant multiply, then a restoring divider retiring one quotient bit per cycle.
module ssko_div #(
  parameter int SW = 36
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SW-1:0]          num_i,
  input  logic signed [SW-1:0]          den_i,
  output logic                          done_o,
  output logic [ssko_pkg::PCT_W-1:0]    pk_o
);

  localparam int QW     = ssko_pkg::PCT_W;
  localparam int MW     = SW - 1;
  localparam int PROD_W = MW + QW;
  localparam int CW     = $clog2(QW);

  ssko_pkg::div_state_e st_q, st_d;

  logic [MW-1:0]     num_q, num_d;
  logic [MW-1:0]     den_q, den_d;
  logic [MW-1:0]     rem_q, rem_d;
  logic [QW-1:0]     sh_q, sh_d;
  logic [QW-1:0]     pk_q, pk_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [PROD_W-1:0] prod;
  logic [SW-1:0]     trial;
  logic [SW-1:0]     diff;
  logic              qbit;

  assign prod  = PROD_W'(num_q) * PROD_W'(ssko_pkg::FULL_SCALE);
  assign trial = {rem_q, sh_q[QW-1]};
  assign diff  = trial - SW'(den_q);
  assign qbit  = (trial >= SW'(den_q));

  always_comb begin
    st_d  = st_q;
    num_d = num_q;
    den_d = den_q;
    rem_d = rem_q;
    sh_d  = sh_q;
    pk_d  = pk_q;
    cnt_d = cnt_q;
    case (st_q)
      ssko_pkg::DIV_IDLE: begin
        if (start_i) begin
          if (den_i <= 0) begin
            pk_d = ssko_pkg::FULL_SCALE;
            st_d = ssko_pkg::DIV_DONE;
          end else if (num_i <= 0) begin
            pk_d = '0;
            st_d = ssko_pkg::DIV_DONE;
          end else if (num_i >= den_i) begin
            pk_d = ssko_pkg::FULL_SCALE;
            st_d = ssko_pkg::DIV_DONE;
          end else begin
            num_d = num_i[MW-1:0];
            den_d = den_i[MW-1:0];
            st_d  = ssko_pkg::DIV_MUL;
          end
        end
      end
      ssko_pkg::DIV_MUL: begin
        // upper part is below num, hence below den
        rem_d = prod[PROD_W-1:QW];
        sh_d  = prod[QW-1:0];
        cnt_d = '0;
        st_d  = ssko_pkg::DIV_RUN;
      end
      ssko_pkg::DIV_RUN: begin
        rem_d = qbit ? diff[MW-1:0] : trial[MW-1:0];
        sh_d  = {sh_q[QW-2:0], qbit};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CW'(QW - 1)) begin
          pk_d = {sh_q[QW-2:0], qbit};
          st_d = ssko_pkg::DIV_DONE;
        end
      end
      ssko_pkg::DIV_DONE: begin
        st_d = ssko_pkg::DIV_IDLE;
      end
      default: st_d = ssko_pkg::DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= ssko_pkg::DIV_IDLE;
      cnt_q <= '0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    den_q <= den_d;
    rem_q <= rem_d;
    sh_q  <= sh_d;
    pk_q  <= pk_d;
  end

  assign done_o = (st_q == ssko_pkg::DIV_DONE);
  assign pk_o   = pk_q;

`ifndef SYNTH
  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ssko_pkg::DIV_RUN |-> rem_q < den_q)
    else $error("divider remainder not below divisor");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("divider done held longer than one cycle");

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> st_q == ssko_pkg::DIV_IDLE)
    else $error("divider started while busy");
`endif

endmodule

### hw/rtl/stochastic_slow_k_oscillator_top.sv
// Slow stochastic %K over a stream of price bars. Each input transaction carries one
// bar; new_bar (tuser) set pushes it into the history, clear overwrites the newest bar.
// Every input transaction yields exactly one output transaction: percent_k in tdata,
// k_valid in tuser; until win_len + slowing bars have been pushed the result is 0
// with k_valid low, and such a bar skips the history sweep and the divider. For a
// valid bar the history memory has one read port and is swept once, newest entry
// first, over win_len + slowing - 1 entries, then a 15-step divider forms the ratio
// (its multiply and steps are skipped when the ratio is pinned at 0 or 100 percent).
// One item is in flight at a time; a finished result waits in the output register
// while the next bar is accepted. win_len (the window register at address 0) and
// slowing are clamped to 1..MAX_K_PERIOD and 1..MAX_SLOWING and must only be written
// while the block is idle. No clearing pass is needed after reset.
module stochastic_slow_k_oscillator_top #(
  parameter int MAX_K_PERIOD = ssko_pkg::DEF_MAX_K_PERIOD,
  parameter int MAX_SLOWING  = ssko_pkg::DEF_MAX_SLOWING,
  parameter int PRICE_WIDTH  = ssko_pkg::DEF_PRICE_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // bar_high, bar_low, bar_close
  input  logic [ssko_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // new_bar
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // percent_k, zero pad
  output logic [ssko_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // k_valid
  output logic                                m_axis_tuser,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ssko_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [ssko_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [ssko_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  localparam int PW    = PRICE_WIDTH;
  localparam int FW    = ssko_pkg::FIELD_W;
  localparam int HIST  = MAX_K_PERIOD + MAX_SLOWING - 1;
  localparam int AW    = (HIST > 1) ? $clog2(HIST) : 1;
  localparam int KW    = $clog2(MAX_K_PERIOD + 1);
  localparam int SLW   = $clog2(MAX_SLOWING + 1);
  localparam int SW    = PW + $clog2(MAX_SLOWING) + 1;
  localparam int RAM_W = 3 * PW;

  ssko_pkg::state_e state_q, state_d;

  logic [ssko_pkg::KP_CFG_W-1:0] kp_cfg_q;
  logic [ssko_pkg::SL_CFG_W-1:0] sl_cfg_q;
  logic [KW-1:0]                 kp_eff;
  logic [SLW-1:0]                sl_eff;
  logic                          cfg_wr;

  logic                          in_accept;
  logic [PW-1:0]                 in_high;
  logic [PW-1:0]                 in_low;
  logic [PW-1:0]                 in_close;

  logic [AW-1:0]                 head_q;
  logic [AW-1:0]                 head_inc;
  logic [AW-1:0]                 wr_addr;
  logic [ssko_pkg::SEEN_W-1:0]   seen_q, seen_d;

  logic [AW-1:0]                 age_q, age_d;
  logic [AW-1:0]                 rd_addr;
  logic                          rd_en;
  logic [RAM_W-1:0]              rd_data;
  logic                          rd_vld_q;
  logic [AW-1:0]                 rd_age_q;
  int                            last_age;

  logic signed [SW-1:0]          lane_num;
  logic signed [SW-1:0]          lane_den;
  logic                          lane_done;
  logic                          div_start;
  logic                          div_done;
  logic [ssko_pkg::PCT_W-1:0]    div_pk;

  logic [ssko_pkg::PCT_W-1:0]    res_pk_q, res_pk_d;
  logic                          res_kv_q, res_kv_d;
  logic                          out_load;
  logic                          m_valid_q;
  logic [ssko_pkg::PCT_W-1:0]    m_pk_q;
  logic                          m_kv_q;

  // ---------------- configuration ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_cfg_q <= ssko_pkg::KP_RESET;
      sl_cfg_q <= ssko_pkg::SL_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == ssko_pkg::REG_K_PERIOD) kp_cfg_q <= pwdata[ssko_pkg::KP_CFG_W-1:0];
      if (paddr[2] == ssko_pkg::REG_SLOWING)  sl_cfg_q <= pwdata[ssko_pkg::SL_CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == ssko_pkg::REG_SLOWING) ? ssko_pkg::APB_DATA_W'(sl_cfg_q)
                                                      : ssko_pkg::APB_DATA_W'(kp_cfg_q);

  always_comb begin
    if (kp_cfg_q == '0) kp_eff = KW'(1);
    else if (int'(kp_cfg_q) > MAX_K_PERIOD) kp_eff = KW'(MAX_K_PERIOD);
    else kp_eff = KW'(kp_cfg_q);

    if (sl_cfg_q == '0) sl_eff = SLW'(1);
    else if (int'(sl_cfg_q) > MAX_SLOWING) sl_eff = SLW'(MAX_SLOWING);
    else sl_eff = SLW'(sl_cfg_q);
  end

  // ---------------- history write side ----------------
  assign s_axis_tready = (state_q == ssko_pkg::ST_IDLE);
  assign in_accept     = s_axis_tvalid & s_axis_tready;
  assign in_high       = PW'(s_axis_tdata[FW-1:0]);
  assign in_low        = PW'(s_axis_tdata[2*FW-1:FW]);
  assign in_close      = PW'(s_axis_tdata[3*FW-1:2*FW]);

  // circular buffer: head holds the newest bar
  assign head_inc = (int'(head_q) == HIST - 1) ? '0 : head_q + 1'b1;
  assign wr_addr  = s_axis_tuser ? head_inc : head_q;

  assign seen_d = (s_axis_tuser && seen_q != ssko_pkg::SEEN_MAX) ? seen_q + 1'b1 : seen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      seen_q <= '0;
    end else if (in_accept) begin
      head_q <= wr_addr;
      seen_q <= seen_d;
    end
  end

  // ---------------- history read sweep ----------------
  // reads start the cycle after the write, so the new bar is already in the array
  always_comb begin
    if (age_q <= head_q) rd_addr = head_q - age_q;
    else rd_addr = AW'(int'(head_q) + HIST - int'(age_q));
  end

  assign rd_en    = (state_q == ssko_pkg::ST_READ);
  assign last_age = int'(kp_eff) + int'(sl_eff) - 2;

  ssko_ram #(
    .WIDTH (RAM_W),
    .DEPTH (HIST)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept),
    .waddr_i (wr_addr),
    .wdata_i ({in_close, in_low, in_high}),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_age_q <= '0;
    end else begin
      rd_vld_q <= rd_en;
      rd_age_q <= age_q;
    end
  end

  ssko_lanes #(
    .PW     (PW),
    .MAX_SL (MAX_SLOWING),
    .AW     (AW),
    .KW     (KW),
    .SLW    (SLW),
    .SW     (SW)
  ) u_lanes (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .clear_i    (in_accept),
    .rd_vld_i   (rd_vld_q),
    .rd_age_i   (rd_age_q),
    .rd_high_i  (rd_data[PW-1:0]),
    .rd_low_i   (rd_data[2*PW-1:PW]),
    .rd_close_i (rd_data[3*PW-1:2*PW]),
    .kp_i       (kp_eff),
    .sl_i       (sl_eff),
    .num_o      (lane_num),
    .den_o      (lane_den),
    .done_o     (lane_done)
  );

  ssko_div #(
    .SW (SW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (lane_num),
    .den_i   (lane_den),
    .done_o  (div_done),
    .pk_o    (div_pk)
  );

  // ---------------- sequencer ----------------
  always_comb begin
    state_d   = state_q;
    age_d     = age_q;
    res_pk_d  = res_pk_q;
    res_kv_d  = res_kv_q;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_q)
      ssko_pkg::ST_IDLE: begin
        if (in_accept) begin
          age_d = '0;
          if (int'(seen_d) >= int'(kp_eff) + int'(sl_eff)) begin
            state_d = ssko_pkg::ST_READ;
          end else begin
            res_pk_d = '0;
            res_kv_d = 1'b0;
            state_d  = ssko_pkg::ST_OUT;
          end
        end
      end
      ssko_pkg::ST_READ: begin
        if (int'(age_q) == last_age) state_d = ssko_pkg::ST_WAIT;
        else age_d = age_q + 1'b1;
      end
      ssko_pkg::ST_WAIT: begin
        if (lane_done) begin
          div_start = 1'b1;
          state_d   = ssko_pkg::ST_DIV;
        end
      end
      ssko_pkg::ST_DIV: begin
        if (div_done) begin
          res_pk_d = div_pk;
          res_kv_d = 1'b1;
          state_d  = ssko_pkg::ST_OUT;
        end
      end
      ssko_pkg::ST_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ssko_pkg::ST_IDLE;
        end
      end
      default: state_d = ssko_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssko_pkg::ST_IDLE;
      age_q   <= '0;
    end else begin
      state_q <= state_d;
      age_q   <= age_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_pk_q <= res_pk_d;
    res_kv_q <= res_kv_d;
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_pk_q <= res_pk_q;
      m_kv_q <= res_kv_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = ssko_pkg::OUT_DATA_W'(m_pk_q);
  assign m_axis_tuser  = m_kv_q;

`ifndef SYNTH
  a_lane_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lane_done |-> state_q == ssko_pkg::ST_WAIT)
    else $error("window sums finished outside the wait state");

  a_seen_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seen_q >= $past(seen_q))
    else $error("bar counter went backwards");

  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("nonzero percent K on a result not yet valid");
`endif

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_D     = ssko_pkg::DEF_MAX_K_PERIOD + ssko_pkg::DEF_MAX_SLOWING - 1;
  localparam int CLOSE_D    = ssko_pkg::DEF_MAX_SLOWING;
  localparam int LONG_HOLD  = 400;
  localparam int SETTLE_CYC = 80;

  typedef logic [ssko_pkg::FIELD_W-1:0] price_t;

  localparam price_t MAX_PRICE = '1;
  localparam price_t P_BASE    = 32'h0064_0000;  // 100.0

  typedef struct packed {
    price_t hi;
    price_t lo;
    price_t cl;
    logic   nb;
  } in_bar_t;

  typedef struct packed {
    logic [ssko_pkg::PCT_W-1:0] pct;
    logic                       kv;
  } kresult_t;

  typedef struct packed {
    in_bar_t                    bar;
    logic                       typed;
    logic [ssko_pkg::PCT_W-1:0] pct;
    logic                       kv;
  } dir_row_t;

  typedef struct packed {
    logic [ssko_pkg::APB_DATA_W-1:0] kp_wr;
    logic [ssko_pkg::APB_DATA_W-1:0] sl_wr;
    int                              gap_pct;
    int                              stall_pct;
    int                              n_items;
    bit                              hold;
    bit                              pause;
  } phase_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [ssko_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;   // bar_high, bar_low, bar_close
  logic                            s_axis_tuser = 1'b0;  // new_bar
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [ssko_pkg::OUT_DATA_W-1:0] m_axis_tdata;        // percent_k, zero pad
  logic                            m_axis_tuser;        // k_valid
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [ssko_pkg::APB_ADDR_W-1:0] paddr = '0;
  logic [ssko_pkg::APB_DATA_W-1:0] pwdata = '0;
  logic [ssko_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  // predictor state
  price_t                        hi_hist [HIST_D];
  price_t                        lo_hist [HIST_D];
  price_t                        cl_hist [CLOSE_D];
  logic [ssko_pkg::SEEN_W-1:0]   bars_cnt;
  logic [ssko_pkg::KP_CFG_W-1:0] win_cfg;
  logic [ssko_pkg::SL_CFG_W-1:0] sum_cfg;

  kresult_t pct_q [$];
  int       mismatch_cnt = 0;
  int       tx_gap_pct = 0;
  int       rx_stall_pct = 0;
  bit       hold_go = 1'b0;
  bit       rx_hold;
  price_t   walk_mid = P_BASE;

  always #4 clk_i = ~clk_i;

  stochastic_slow_k_oscillator_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_cnt++;
  endtask

  // Advances the predictor by one bar and returns the slow %K it yields.
  function automatic kresult_t slow_k_next(input in_bar_t b);
    int       kp, sl, i, j;
    longint   nsum, dsum, ratio;
    price_t   hh, ll;
    kresult_t r;
    if (b.nb) begin
      for (i = HIST_D - 1; i > 0; i--) begin
        hi_hist[i] = hi_hist[i-1];
        lo_hist[i] = lo_hist[i-1];
      end
      for (i = CLOSE_D - 1; i > 0; i--) cl_hist[i] = cl_hist[i-1];
      if (bars_cnt != ssko_pkg::SEEN_MAX) bars_cnt++;
    end
    hi_hist[0] = b.hi;
    lo_hist[0] = b.lo;
    cl_hist[0] = b.cl;

    kp = int'(win_cfg);
    sl = int'(sum_cfg);
    if (kp == 0) kp = 1;
    if (kp > ssko_pkg::DEF_MAX_K_PERIOD) kp = ssko_pkg::DEF_MAX_K_PERIOD;
    if (sl == 0) sl = 1;
    if (sl > ssko_pkg::DEF_MAX_SLOWING) sl = ssko_pkg::DEF_MAX_SLOWING;

    r = '0;
    if (int'(bars_cnt) < kp + sl) return r;

    nsum = 0;
    dsum = 0;
    for (j = 0; j < sl; j++) begin
      hh = hi_hist[j];
      ll = lo_hist[j];
      for (i = j + 1; i < j + kp; i++) begin
        if (hi_hist[i] > hh) hh = hi_hist[i];
        if (lo_hist[i] < ll) ll = lo_hist[i];
      end
      nsum += $signed({32'h0, cl_hist[j]}) - $signed({32'h0, ll});
      dsum += $signed({32'h0, hh}) - $signed({32'h0, ll});
    end
    r.kv = 1'b1;
    if (dsum <= 0) begin
      r.pct = ssko_pkg::FULL_SCALE;
    end else if (nsum <= 0) begin
      r.pct = '0;
    end else if (nsum >= dsum) begin
      r.pct = ssko_pkg::FULL_SCALE;
    end else begin
      ratio = (nsum * longint'(ssko_pkg::FULL_SCALE)) / dsum;
      r.pct = ratio[ssko_pkg::PCT_W-1:0];
    end
    return r;
  endfunction

  // Mostly bars with low <= close <= high around a drifting price, the rest noise.
  function automatic in_bar_t random_bar();
    in_bar_t b;
    longint  hi_l, lo_l, span;
    int      sh;
    if ($urandom_range(99) < 80) begin
      if ($urandom_range(39) == 0) walk_mid = $urandom;
      sh = $urandom_range(20);
      hi_l = $signed({32'h0, walk_mid}) + longint'($urandom_range(1 << sh));
      lo_l = $signed({32'h0, walk_mid}) - longint'($urandom_range(1 << sh));
      if (hi_l > $signed({32'h0, MAX_PRICE})) hi_l = $signed({32'h0, MAX_PRICE});
      if (lo_l < 1) lo_l = 1;
      span = hi_l - lo_l + 1;
      b.hi = hi_l[ssko_pkg::FIELD_W-1:0];
      b.lo = lo_l[ssko_pkg::FIELD_W-1:0];
      b.cl = price_t'(lo_l + (longint'($urandom) % span));
      walk_mid = b.cl;
    end else begin
      b.hi = $urandom;
      b.lo = $urandom;
      b.cl = $urandom;
    end
    b.nb = ($urandom_range(99) < 85);
    return b;
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic send_bar(input in_bar_t b, input logic typed, input kresult_t fixed);
    kresult_t want;
    while ($urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {b.cl, b.lo, b.hi};
    s_axis_tuser  <= b.nb;
    do @(posedge clk_i); while (!s_axis_tready);
    want = slow_k_next(b);
    if (typed) want = fixed;
    pct_q.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic drain_results(input int extra);
    s_axis_tvalid <= 1'b0;
    while (pct_q.size() != 0) @(negedge clk_i);
    repeat (extra) @(negedge clk_i);
  endtask

  // Returns at a falling edge after the bus went idle.
  task automatic write_reg(input logic sel, input logic [ssko_pkg::APB_DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (sel == ssko_pkg::REG_K_PERIOD) win_cfg = val[ssko_pkg::KP_CFG_W-1:0];
    else sum_cfg = val[ssko_pkg::SL_CFG_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Receiver side: random stalls, plus one long hold-off on request.
  initial begin
    rx_hold = 1'b0;
    wait (hold_go);
    @(posedge clk_i);
    rx_hold = 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    rx_hold = 1'b0;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk_i) begin
    kresult_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pct_q.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = pct_q.pop_front();
        if (m_axis_tdata[ssko_pkg::PCT_W-1:0] !== want.pct)
          report_mismatch($sformatf("percent_k got %0d want %0d",
                                    m_axis_tdata[ssko_pkg::PCT_W-1:0], want.pct));
        if (m_axis_tuser !== want.kv)
          report_mismatch($sformatf("k_valid got %b want %b", m_axis_tuser, want.kv));
      end
    end
  end

  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

  dir_row_t dir_rows [25] = '{
    // replace before any bar was pushed
    '{'{MAX_PRICE, 32'd1, MAX_PRICE, 1'b0}, 1'b1, 15'd0, 1'b0},
    '{'{MAX_PRICE, 32'd1, 32'd1, 1'b1},     1'b1, 15'd0, 1'b0},
    '{'{P_BASE, P_BASE, P_BASE, 1'b1},      1'b1, 15'd0, 1'b0},
    '{'{P_BASE, P_BASE, P_BASE, 1'b1},      1'b1, 15'd0, 1'b0},
    '{'{P_BASE, P_BASE, P_BASE, 1'b1},      1'b1, 15'd0, 1'b0},
    '{'{P_BASE, P_BASE, P_BASE, 1'b1},      1'b1, 15'd0, 1'b0},
    '{'{P_BASE, P_BASE, P_BASE, 1'b1},      1'b1, 15'd0, 1'b0},
    '{'{P_BASE, P_BASE, P_BASE, 1'b1},      1'b1, 15'd0, 1'b0},
    // first valid bar, flat window: zero range reads as full scale
    '{'{P_BASE, P_BASE, P_BASE, 1'b1},      1'b1, ssko_pkg::FULL_SCALE, 1'b1},
    '{'{P_BASE, P_BASE, P_BASE, 1'b0},      1'b1, ssko_pkg::FULL_SCALE, 1'b1},
    // close below the lowest low, then above the highest high
    '{'{P_BASE + 32'd100, P_BASE, 32'd1, 1'b0},     1'b0, 15'd0, 1'b0},
    '{'{P_BASE + 32'd100, P_BASE, MAX_PRICE, 1'b0}, 1'b0, 15'd0, 1'b0},
    '{'{P_BASE + 32'd400, P_BASE, P_BASE + 32'd100, 1'b0}, 1'b0, 15'd0, 1'b0},
    '{'{MAX_PRICE, 32'd1, 32'h8000_0000, 1'b1},     1'b0, 15'd0, 1'b0},
    '{'{32'd0, 32'd0, 32'd0, 1'b1},                 1'b0, 15'd0, 1'b0},
    // low above high over the whole window: negative range
    '{'{32'd1, MAX_PRICE, P_BASE, 1'b1},    1'b0, 15'd0, 1'b0},
    '{'{32'd1, MAX_PRICE, P_BASE, 1'b1},    1'b0, 15'd0, 1'b0},
    '{'{32'd1, MAX_PRICE, P_BASE, 1'b1},    1'b0, 15'd0, 1'b0},
    '{'{32'd1, MAX_PRICE, P_BASE, 1'b1},    1'b0, 15'd0, 1'b0},
    '{'{32'd1, MAX_PRICE, P_BASE, 1'b1},    1'b0, 15'd0, 1'b0},
    '{'{32'd1, MAX_PRICE, P_BASE, 1'b1},    1'b0, 15'd0, 1'b0},
    '{'{32'd1, MAX_PRICE, P_BASE, 1'b1},    1'b1, ssko_pkg::FULL_SCALE, 1'b1},
    '{'{P_BASE, P_BASE - 32'h1_0000, P_BASE - 32'h8000, 1'b0}, 1'b0, 15'd0, 1'b0},
    '{'{MAX_PRICE, MAX_PRICE, MAX_PRICE, 1'b1},     1'b0, 15'd0, 1'b0},
    '{'{32'd1, 32'd1, 32'd1, 1'b1},                 1'b0, 15'd0, 1'b0}
  };

  // window / slowing writes include out-of-range values and stray upper bits
  phase_t phases [9] = '{
    '{32'd1,          32'd1,          0,  0,  110, 1'b0, 1'b0},
    '{32'd32,         32'd8,          57, 0,  110, 1'b1, 1'b0},
    '{32'd0,          32'd0,          0,  57, 110, 1'b0, 1'b0},
    '{32'd63,         32'd15,         18, 18, 110, 1'b0, 1'b1},
    '{32'hFFFF_FFC7,  32'hFFFF_FFF2,  57, 0,  110, 1'b0, 1'b0},
    '{32'd33,         32'd9,          0,  0,  110, 1'b0, 1'b0},
    '{32'd2,          32'd8,          18, 18, 110, 1'b0, 1'b0},
    '{32'd32,         32'd1,          0,  57, 110, 1'b0, 1'b0},
    '{32'd5,          32'd3,          0,  0,  110, 1'b0, 1'b0}
  };

  initial begin
    int i, p;
    foreach (hi_hist[k]) begin
      hi_hist[k] = '0;
      lo_hist[k] = '0;
    end
    foreach (cl_hist[k]) cl_hist[k] = '0;
    bars_cnt = '0;
    win_cfg  = ssko_pkg::KP_RESET;
    sum_cfg  = ssko_pkg::SL_RESET;

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (i = 0; i < 25; i++)
      send_bar(dir_rows[i].bar, dir_rows[i].typed, '{dir_rows[i].pct, dir_rows[i].kv});
    drain_results(4);

    for (p = 0; p < 9; p++) begin
      write_reg(ssko_pkg::REG_K_PERIOD, phases[p].kp_wr);
      write_reg(ssko_pkg::REG_SLOWING, phases[p].sl_wr);
      tx_gap_pct   = phases[p].gap_pct;
      rx_stall_pct = phases[p].stall_pct;
      for (i = 0; i < phases[p].n_items; i++) begin
        if (phases[p].hold && i == 30) hold_go = 1'b1;
        // sender waits for every outstanding result mid-phase
        if (phases[p].pause && i == 55) drain_results(0);
        send_bar(random_bar(), 1'b0, '0);
      end
      drain_results(4);
    end

    drain_results(SETTLE_CYC);
    if (mismatch_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
